FILE: design/gml_pkg.sv
`timescale 1ns / 1ps

package gml_pkg;

    localparam int GML_TABLE_DEPTH  = 256;
    localparam int GML_MAX_CHANNELS = 4;
    localparam int GML_OUT_FIELDS   = 4;

    // 1.0 in the Q1.16 interpolation weight
    localparam logic [16:0] GML_FRAC_ONE = 17'h10000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    localparam logic [31:0] RST_LOW_VALUE      = 32'h0000_0000;
    localparam logic [31:0] RST_POSITION_SCALE = 32'h00FF_0000;
    localparam logic [8:0]  RST_ENTRIES        = 9'd256;
    localparam logic [2:0]  RST_CHANNELS       = 3'd4;

    typedef enum logic [1:0] {
        CFG_LOW_VALUE      = 2'd0,
        CFG_POSITION_SCALE = 2'd1,
        CFG_ENTRIES        = 2'd2,
        CFG_CHANNELS       = 2'd3
    } gml_cfg_idx_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         entry_index;
        logic [1:0]         entry_channel;
        logic [15:0]        entry_value;
        logic signed [31:0] sample;
    } gml_in_t;

    typedef struct packed {
        logic [15:0] channel_0;
        logic [15:0] channel_1;
        logic [15:0] channel_2;
        logic [15:0] channel_3;
    } gml_out_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mul_en;
        logic out_en;
    } gml_lane_ctl_t;

endpackage

FILE: design/gml_ram.sv
`timescale 1ns / 1ps

module gml_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/gml_lane.sv
`timescale 1ns / 1ps

module gml_lane
    import gml_pkg::*;
#(
    parameter int TABLE_DEPTH = GML_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          clk,
    input  gml_lane_ctl_t ctl,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr0,
    input  logic [AW-1:0] rd_addr1,
    input  logic [15:0]   frac,
    input  logic          lane_on,
    output logic [15:0]   result
);

    logic [15:0] e0;
    logic [15:0] e1;
    logic [16:0] w0;
    logic [32:0] m0_next;
    logic [31:0] m1_next;
    logic [32:0] m0_reg;
    logic [31:0] m1_reg;
    logic        on6_reg;
    logic [31:0] sum_next;
    logic [15:0] res_reg;

    // two copies of the channel so both neighbors are read in the same cycle
    gml_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_ram0 (
        .clk    (clk),
        .wr_en  (ctl.wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (ctl.rd_en),
        .rd_addr(rd_addr0),
        .rd_data(e0)
    );

    gml_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_ram1 (
        .clk    (clk),
        .wr_en  (ctl.wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (ctl.rd_en),
        .rd_addr(rd_addr1),
        .rd_data(e1)
    );

    always_comb
    begin
        w0       = GML_FRAC_ONE - {1'b0, frac};
        m0_next  = 33'(e0) * 33'(w0);
        m1_next  = 32'(e1) * 32'(frac);
        // e0*(1-f) + e1*f never exceeds 0xffff0000
        sum_next = m0_reg[31:0] + m1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            on6_reg <= lane_on;
        end
        if (ctl.out_en)
        begin
            res_reg <= on6_reg ? sum_next[31:16] : 16'd0;
        end
    end

    assign result = res_reg;

endmodule

FILE: design/gradient_map_lerp.sv
`timescale 1ns / 1ps
// load beats end at the table write; map beats give their result on out_valid
// throughput: one beat per cycle; a stalled stage holds and only the stages
//   behind it wait, so bubbles are squeezed out under output stall
// reset clears all stage valid bits and sets the configuration registers to
//   their defaults; the gradient table is not cleared and reads undefined until loaded
module gradient_map_lerp
    import gml_pkg::*;
#(
    parameter int TABLE_DEPTH  = GML_TABLE_DEPTH,
    parameter int MAX_CHANNELS = GML_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gml_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output gml_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // configuration
    logic signed [31:0] low_value_reg;
    logic signed [31:0] position_scale_reg;
    logic [8:0]         entries_reg;
    logic [2:0]         channels_reg;

    // stage valids and advance enables
    logic [7:1] vld_reg;
    logic [7:1] vld_next;
    logic [8:1] en;

    // stage 1: difference
    logic               kind1_reg;
    logic [7:0]         idx1_reg;
    logic [1:0]         ch1_reg;
    logic [15:0]        val1_reg;
    logic signed [32:0] diff_next;
    logic signed [32:0] diff1_reg;

    // stage 2: partial products
    logic               kind2_reg;
    logic [7:0]         idx2_reg;
    logic [1:0]         ch2_reg;
    logic [15:0]        val2_reg;
    logic signed [49:0] plo_next;
    logic signed [48:0] phi_next;
    logic signed [49:0] plo2_reg;
    logic signed [48:0] phi2_reg;

    // stage 3: position
    logic               kind3_reg;
    logic [7:0]         idx3_reg;
    logic [1:0]         ch3_reg;
    logic [15:0]        val3_reg;
    logic signed [64:0] pos_next;
    logic [63:0]        pos3_reg;

    // stage 4: addresses and weight
    logic                      kind4_reg;
    logic [7:0]                idx4_reg;
    logic [1:0]                ch4_reg;
    logic [15:0]               val4_reg;
    logic [AW-1:0]             last_idx;
    logic                      below;
    logic                      above;
    logic [AW-1:0]             base_idx;
    logic [AW-1:0]             a0_next;
    logic [AW-1:0]             a1_next;
    logic [15:0]               f_next;
    logic [GML_OUT_FIELDS-1:0] on_next;
    logic [AW-1:0]             a0_4_reg;
    logic [AW-1:0]             a1_4_reg;
    logic [15:0]               f4_reg;
    logic [GML_OUT_FIELDS-1:0] on4_reg;

    // stage 5: table read
    logic [15:0]               f5_reg;
    logic [GML_OUT_FIELDS-1:0] on5_reg;

    logic                      load_ok;
    logic [15:0]               lane_res [GML_OUT_FIELDS];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_value_reg      <= RST_LOW_VALUE;
            position_scale_reg <= RST_POSITION_SCALE;
            entries_reg        <= RST_ENTRIES;
            channels_reg       <= RST_CHANNELS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gml_cfg_idx_t'(cfg_index))
                CFG_LOW_VALUE:      low_value_reg      <= cfg_data;
                CFG_POSITION_SCALE: position_scale_reg <= cfg_data;
                CFG_ENTRIES:        entries_reg        <= cfg_data[8:0];
                CFG_CHANNELS:       channels_reg       <= cfg_data[2:0];
            endcase
        end
    end

    // stall chain: a stage may load when it is empty or its content moves on
    always_comb
    begin
        en[8] = !out_stall;
        for (int k = 7; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[1] = in_valid;
        vld_next[2] = vld_reg[1];
        vld_next[3] = vld_reg[2];
        vld_next[4] = vld_reg[3];
        // load beats end at the table write
        vld_next[5] = vld_reg[4] && (kind4_reg == KIND_MAP);
        vld_next[6] = vld_reg[5];
        vld_next[7] = vld_reg[6];
    end

    assign in_stall  = !en[1];
    assign out_valid = vld_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= 7; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // datapath
    always_comb
    begin
        diff_next = 33'(in_data.sample) - 33'(low_value_reg);
        // 33 by 17 and 33 by 16 bit signed products
        plo_next  = 50'(diff1_reg) * 50'($signed({1'b0, position_scale_reg[15:0]}));
        phi_next  = 49'(diff1_reg) * 49'($signed(position_scale_reg[31:16]));
        pos_next  = (65'(phi2_reg) <<< 16) + 65'(plo2_reg);

        if (entries_reg == 9'd0)
        begin
            last_idx = '0;
        end
        else if (32'(entries_reg) > 32'(TABLE_DEPTH))
        begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = AW'(entries_reg - 9'd1);
        end

        // clamp below the first entry and at or past the last one
        below    = pos3_reg[63] || (pos3_reg == '0);
        above    = !pos3_reg[63] && (pos3_reg[63:32] >= 32'(last_idx));
        base_idx = pos3_reg[32 +: AW];
        if (below)
        begin
            a0_next = '0;
            a1_next = '0;
            f_next  = '0;
        end
        else if (above)
        begin
            a0_next = last_idx;
            a1_next = last_idx;
            f_next  = '0;
        end
        else
        begin
            a0_next = base_idx;
            a1_next = base_idx + AW'(1);
            f_next  = pos3_reg[31:16];
        end

        for (int k = 0; k < GML_OUT_FIELDS; k++)
        begin
            on_next[k] = (3'(k) < channels_reg) && (k < MAX_CHANNELS);
        end

        load_ok = vld_reg[4] && (kind4_reg == KIND_LOAD) && en[5]
                  && (32'(idx4_reg) < 32'(TABLE_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind1_reg <= in_data.kind;
            idx1_reg  <= in_data.entry_index;
            ch1_reg   <= in_data.entry_channel;
            val1_reg  <= in_data.entry_value;
            diff1_reg <= diff_next;
        end
        if (en[2])
        begin
            kind2_reg <= kind1_reg;
            idx2_reg  <= idx1_reg;
            ch2_reg   <= ch1_reg;
            val2_reg  <= val1_reg;
            plo2_reg  <= plo_next;
            phi2_reg  <= phi_next;
        end
        if (en[3])
        begin
            kind3_reg <= kind2_reg;
            idx3_reg  <= idx2_reg;
            ch3_reg   <= ch2_reg;
            val3_reg  <= val2_reg;
            pos3_reg  <= pos_next[63:0];
        end
        if (en[4])
        begin
            kind4_reg <= kind3_reg;
            idx4_reg  <= idx3_reg;
            ch4_reg   <= ch3_reg;
            val4_reg  <= val3_reg;
            a0_4_reg  <= a0_next;
            a1_4_reg  <= a1_next;
            f4_reg    <= f_next;
            on4_reg   <= on_next;
        end
        if (en[5])
        begin
            f5_reg  <= f4_reg;
            on5_reg <= on4_reg;
        end
    end

    // one lane per channel; loads write in the same stage as map reads so
    // table accesses stay in beat order
    for (genvar k = 0; k < GML_OUT_FIELDS; k++)
    begin : g_lane
        if (k < MAX_CHANNELS)
        begin : g_on
            gml_lane_ctl_t ctl;

            always_comb
            begin
                ctl.wr_en  = load_ok && (ch4_reg == 2'(k));
                ctl.rd_en  = en[5];
                ctl.mul_en = en[6];
                ctl.out_en = en[7];
            end

            gml_lane #(
                .TABLE_DEPTH(TABLE_DEPTH)
            ) u_lane (
                .clk     (clk),
                .ctl     (ctl),
                .wr_addr (AW'(idx4_reg)),
                .wr_data (val4_reg),
                .rd_addr0(a0_4_reg),
                .rd_addr1(a1_4_reg),
                .frac    (f5_reg),
                .lane_on (on5_reg[k]),
                .result  (lane_res[k])
            );
        end
        else
        begin : g_off
            assign lane_res[k] = 16'd0;
        end
    end

    assign out_data.channel_0 = lane_res[0];
    assign out_data.channel_1 = lane_res[1];
    assign out_data.channel_2 = lane_res[2];
    assign out_data.channel_3 = lane_res[3];

endmodule

FILE: design/gml_checker.sv
`timescale 1ns / 1ps

module gml_checker
    import gml_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input gml_out_t out_data,
    input logic     cfg_valid,
    input logic     cfg_ready
);

    // a waiting result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // input only backs up when the whole pipe is blocked at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side can move");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    // configuration writes are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind gradient_map_lerp gml_checker u_gml_checker (.*);
